// ===== src/obbsat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared widths for the oriented box overlap pipeline.
// ----------------------------------------------------------------------------
package obbsat_pkg;
	localparam int CW = 24;   // centre, Q15.8
	localparam int RW = 16;   // cosine and sine, Q1.14
	localparam int HW = 16;   // half extents, Q8.8
	localparam int VW = RW + 1;   // axis component, holds the negated sine
	localparam int DW = CW + 1;   // centre difference
	localparam int DOTW = 2 * VW;          // axis by axis dot product
	localparam int CDOTW = DW + VW + 1;    // centre difference on an axis
	localparam int NAX = 4;                // a.u, a.v, b.u, b.v
endpackage

// ===== src/obb_overlap_test_2d_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_overlap_test_2d_top
// Separating axis overlap test for two oriented rectangles.
// ----------------------------------------------------------------------------
// path: an accepted word is registered in stages 1 and 2, then lands as overlap on the output register
// throughput: one word per cycle; each stage holds while the stage after it is full
//   and stalled, so bubbles are squeezed out under stall
// stages: axis dot products, extent products and squares, final compares
// reset: arst_n clears the stage valid bits only; no other state
module obb_overlap_test_2d_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [obbsat_pkg::CW-1:0] a_center_x,
	input  logic signed [obbsat_pkg::CW-1:0] a_center_y,
	input  logic signed [obbsat_pkg::RW-1:0] a_cosine,
	input  logic signed [obbsat_pkg::RW-1:0] a_sine,
	input  logic [obbsat_pkg::HW-1:0] a_half_w,
	input  logic [obbsat_pkg::HW-1:0] a_half_h,
	input  logic signed [obbsat_pkg::CW-1:0] b_center_x,
	input  logic signed [obbsat_pkg::CW-1:0] b_center_y,
	input  logic signed [obbsat_pkg::RW-1:0] b_cosine,
	input  logic signed [obbsat_pkg::RW-1:0] b_sine,
	input  logic [obbsat_pkg::HW-1:0] b_half_w,
	input  logic [obbsat_pkg::HW-1:0] b_half_h,
	output logic out_valid,
	input  logic out_stall,
	output logic overlap
);
	localparam int VW = obbsat_pkg::VW;
	localparam int HW = obbsat_pkg::HW;
	localparam int DW = obbsat_pkg::DW;
	localparam int NAX = obbsat_pkg::NAX;
	localparam int DOTW = obbsat_pkg::DOTW;
	localparam int CDOTW = obbsat_pkg::CDOTW;
	localparam int ADW = DOTW - 1;          // magnitude of an axis dot
	localparam int EXW = VW + HW + 2;       // sum of four extent terms
	localparam int RADW = ADW + HW + 2;     // projected radius sum
	localparam int SQW = 2 * EXW;
	localparam int DSQW = 2 * DW;
	localparam int R2W = SQW + 1;
	localparam int D2W = DSQW + 1 + 2 * (obbsat_pkg::RW - 2);
	localparam int CAW = CDOTW;
	localparam int SCW = CAW + obbsat_pkg::RW - 2;

	logic v1_s1, v2_s2, v3_s3;
	logic en1, en2, en3;

	assign en3 = !v3_s3 || !out_stall;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign in_stall = !en1;

	// ---------------- stage 1: dot products ----------------
	logic signed [VW-1:0] vx [NAX];
	logic signed [VW-1:0] vy [NAX];
	logic [HW-1:0] h [NAX];
	logic signed [DW-1:0] dx, dy;
	logic signed [DOTW-1:0] dot [NAX][NAX];
	logic signed [CDOTW-1:0] cdot [NAX];
	logic [VW-1:0] mx [NAX];
	logic [VW-1:0] my [NAX];
	logic [EXW-1:0] sx_c, sy_c;

	assign vx[0] = VW'(a_cosine);
	assign vy[0] = VW'(a_sine);
	assign vx[1] = -VW'(a_sine);
	assign vy[1] = VW'(a_cosine);
	assign vx[2] = VW'(b_cosine);
	assign vy[2] = VW'(b_sine);
	assign vx[3] = -VW'(b_sine);
	assign vy[3] = VW'(b_cosine);
	assign h[0] = a_half_w;
	assign h[1] = a_half_h;
	assign h[2] = b_half_w;
	assign h[3] = b_half_h;
	assign dx = DW'(a_center_x) - DW'(b_center_x);
	assign dy = DW'(a_center_y) - DW'(b_center_y);

	for (genvar i = 0; i < NAX; i++) begin : g_ax
		for (genvar j = 0; j < NAX; j++) begin : g_vec
			obbsat_dot #(.AW(VW), .BW(VW), .PW(DOTW)) u_dot (
				.ax(vx[i]), .ay(vy[i]), .bx(vx[j]), .by(vy[j]), .p(dot[i][j])
			);
		end
		obbsat_dot #(.AW(DW), .BW(VW), .PW(CDOTW)) u_cdot (
			.ax(dx), .ay(dy), .bx(vx[i]), .by(vy[i]), .p(cdot[i])
		);
		assign mx[i] = vx[i][VW-1] ? VW'(-vx[i]) : VW'(vx[i]);
		assign my[i] = vy[i][VW-1] ? VW'(-vy[i]) : VW'(vy[i]);
	end

	// axis-aligned extent of both boxes together
	always_comb begin
		sx_c = '0;
		sy_c = '0;
		for (int k = 0; k < NAX; k++) begin
			sx_c = sx_c + EXW'(mx[k]) * EXW'(h[k]);
			sy_c = sy_c + EXW'(my[k]) * EXW'(h[k]);
		end
	end

	logic [ADW-1:0] adot_s1 [NAX][NAX];
	logic signed [CDOTW-1:0] cdot_s1 [NAX];
	logic [HW-1:0] h_s1 [NAX];
	logic [EXW-1:0] sx_s1, sy_s1;
	logic [DW-1:0] dxa_s1, dya_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			for (int i = 0; i < NAX; i++) begin
				for (int j = 0; j < NAX; j++) begin
					adot_s1[i][j] <= dot[i][j][DOTW-1] ? ADW'(-dot[i][j]) : ADW'(dot[i][j]);
				end
				cdot_s1[i] <= cdot[i];
				h_s1[i] <= h[i];
			end
			sx_s1 <= sx_c;
			sy_s1 <= sy_c;
			dxa_s1 <= dx[DW-1] ? DW'(-dx) : DW'(dx);
			dya_s1 <= dy[DW-1] ? DW'(-dy) : DW'(dy);
		end
	end

	// ---------------- stage 2: radii and squares ----------------
	logic [RADW-1:0] rad_c [NAX];

	always_comb begin
		for (int i = 0; i < NAX; i++) begin
			rad_c[i] = '0;
			for (int j = 0; j < NAX; j++) begin
				rad_c[i] = rad_c[i] + RADW'(adot_s1[i][j]) * RADW'(h_s1[j]);
			end
		end
	end

	logic [RADW-1:0] rad_s2 [NAX];
	logic [CAW-1:0] ca_s2 [NAX];
	logic [SQW-1:0] sx2_s2, sy2_s2;
	logic [DSQW-1:0] dx2_s2, dy2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_s1) begin
			for (int i = 0; i < NAX; i++) begin
				rad_s2[i] <= rad_c[i];
				ca_s2[i] <= cdot_s1[i][CDOTW-1] ? CAW'(-cdot_s1[i]) : CAW'(cdot_s1[i]);
			end
			sx2_s2 <= SQW'(sx_s1) * SQW'(sx_s1);
			sy2_s2 <= SQW'(sy_s1) * SQW'(sy_s1);
			dx2_s2 <= DSQW'(dxa_s1) * DSQW'(dxa_s1);
			dy2_s2 <= DSQW'(dya_s1) * DSQW'(dya_s1);
		end
	end

	// ---------------- stage 3: compares ----------------
	logic [R2W-1:0] r2_c;
	logic [D2W-1:0] d2_c;
	logic [NAX-1:0] sep_c;
	logic hit_c;

	always_comb begin
		r2_c = R2W'(sx2_s2) + R2W'(sy2_s2);
		// centres carry an extra 2^14 each, so the squared distance gets 2^28
		d2_c = {(D2W - 2 * (obbsat_pkg::RW - 2))'(DSQW'(dx2_s2) + (DSQW + 1)'(dy2_s2)),
			(2 * (obbsat_pkg::RW - 2))'(0)};
		for (int i = 0; i < NAX; i++) begin
			sep_c[i] = {ca_s2[i], (obbsat_pkg::RW - 2)'(0)} > SCW'(rad_s2[i]);
		end
		hit_c = (D2W'(r2_c) >= d2_c) && (sep_c == '0);
	end

	logic ov_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v2_s2) begin
			ov_s3 <= hit_c;
		end
	end

	assign out_valid = v3_s3;
	assign overlap = ov_s3;

	// input only stalls when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v1_s1 && v2_s2 && v3_s3 && out_stall))
		else $error("input stalled with a free stage");

	// a full middle stage is never dropped while the output waits
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_s2 && v3_s3 && out_stall) |=> v2_s2)
		else $error("stage 2 word lost under stall");

	// a word in stage 3 that was stalled is still there next cycle
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && out_stall) |=> (v3_s3 && $stable(ov_s3)))
		else $error("output word changed under stall");
endmodule

// ===== src/obbsat_dot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbsat_dot
// Signed two element dot product, computed at the output width PW.
// ----------------------------------------------------------------------------
module obbsat_dot #(
	parameter int AW = obbsat_pkg::VW,
	parameter int BW = obbsat_pkg::VW,
	parameter int PW = obbsat_pkg::DOTW
) (
	input  logic signed [AW-1:0] ax,
	input  logic signed [AW-1:0] ay,
	input  logic signed [BW-1:0] bx,
	input  logic signed [BW-1:0] by,
	output logic signed [PW-1:0] p
);
	logic signed [PW-1:0] px;
	logic signed [PW-1:0] py;

	assign px = PW'(ax) * PW'(bx);
	assign py = PW'(ay) * PW'(by);
	assign p  = px + py;
endmodule
